// File: design/gpcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_pkg
// Shared types and constants for the gripper poll command sequencer.
// ----------------------------------------------------------------------------
package gpcs_pkg;

  // Fixed point format of all fractions: 1 << FRAC_BITS means 1.0
  localparam int FRAC_BITS = 12;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam logic [FRAC_W-1:0] ONE_Q = FRAC_W'(1) << FRAC_BITS;

  localparam int BYTE_W    = 8;
  localparam int ELAPSED_W = 24;
  localparam int VEL_W     = 32;

  // Velocity scaling: microseconds per second
  localparam int USEC_W = 20;
  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

  // Shared divider: dividend holds |dpos| * 1e6 * 2^FRAC_BITS,
  // divisor holds |span| * elapsed_us
  localparam int DIV_N     = BYTE_W + USEC_W + FRAC_BITS;
  localparam int DIV_D     = BYTE_W + ELAPSED_W;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);
  localparam int POS_W     = BYTE_W + FRAC_BITS;

  // Command action codes and fixed command values
  localparam logic [BYTE_W-1:0] ACT_RESET     = 8'h00;
  localparam logic [BYTE_W-1:0] ACT_ENABLE    = 8'h01;
  localparam logic [BYTE_W-1:0] ACT_ENABLE_GO = 8'h09;
  localparam logic [BYTE_W-1:0] FULL_SPEED    = 8'hFF;
  localparam logic [BYTE_W-1:0] ACT_FORCE     = 8'h96;

  // Result kinds
  localparam logic KIND_CMD    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_POS,
    ST_VEL,
    ST_EMIT
  } gpcs_state_t;

  // Result slots of one poll, in output order
  typedef enum logic [1:0] {
    SLOT_RESET,
    SLOT_ENABLE,
    SLOT_REPORT,
    SLOT_FINAL
  } gpcs_slot_t;

  typedef struct packed {
    logic [BYTE_W-1:0] open_position;
    logic [BYTE_W-1:0] closed_position;
  } gpcs_cfg_t;

  // One classified poll, passed from the front to the back
  typedef struct packed {
    logic                 act_req;
    logic                 activated;
    logic                 moving;
    logic                 has_final;
    logic [BYTE_W-1:0]    fin_action;
    logic [BYTE_W-1:0]    fin_position;
    logic [BYTE_W-1:0]    fin_speed;
    logic [BYTE_W-1:0]    fin_force;
    logic [BYTE_W-1:0]    prev_raw;
    logic [BYTE_W-1:0]    raw;
    logic [BYTE_W-1:0]    current;
    logic [BYTE_W-1:0]    fault;
    logic [ELAPSED_W-1:0] elapsed;
  } gpcs_job_t;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [BYTE_W-1:0] action_code;
    logic [BYTE_W-1:0] cmd_position;
    logic [BYTE_W-1:0] cmd_speed;
    logic [BYTE_W-1:0] cmd_force;
    logic              activated;
    logic              moving;
    logic [FRAC_W-1:0] position;
    logic [VEL_W-1:0]  velocity;
    logic [BYTE_W-1:0] current;
    logic [BYTE_W-1:0] fault;
  } gpcs_result_t;

endpackage

// File: design/gripper_poll_command_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gripper_poll_command_sequencer
// Turns gripper poll items into command writes and state reports.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | carries
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | one poll item: requests, targets, bytes
//  out     | out_valid / out_ready | one result item: command write or report
//  cfg     | cfg_write             | open_position (0), closed_position (1)
//
//  Sequence: the back end loads a poll, prepares the operands, runs the
//  position divide and then the velocity divide on the shared
//  one-bit-per-cycle divider, then emits each result in turn (one to
//  four results).
//  Reset: synchronous, active high; open 0, closed 255, previous position 0,
//  command pending set, queue empty, no result valid.
//  Stalls: the front takes items while the queue has room, so up to
//  QUEUE_DEPTH polls wait while the back works; out_ready low holds the
//  output register and the back waits in its emit phase.
//
module gripper_poll_command_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [gpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gpcs_pkg::BYTE_W-1:0]        cfg_data,
  // poll items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               activate_request,
  input  logic                               hold_request,
  input  logic                               new_target,
  input  logic [gpcs_pkg::FRAC_W-1:0]        target_position,
  input  logic [gpcs_pkg::FRAC_W-1:0]        target_speed,
  input  logic [gpcs_pkg::FRAC_W-1:0]        target_force,
  input  logic [gpcs_pkg::BYTE_W-1:0]        status_byte,
  input  logic [gpcs_pkg::BYTE_W-1:0]        fault_byte,
  input  logic [gpcs_pkg::BYTE_W-1:0]        position_raw,
  input  logic [gpcs_pkg::BYTE_W-1:0]        current_raw,
  input  logic [gpcs_pkg::ELAPSED_W-1:0]     elapsed_us,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind,
  output logic                               last,
  output logic [gpcs_pkg::BYTE_W-1:0]        action_code,
  output logic [gpcs_pkg::BYTE_W-1:0]        cmd_position,
  output logic [gpcs_pkg::BYTE_W-1:0]        cmd_speed,
  output logic [gpcs_pkg::BYTE_W-1:0]        cmd_force,
  output logic                               activated,
  output logic                               moving,
  output logic [gpcs_pkg::FRAC_W-1:0]        position,
  output logic signed [gpcs_pkg::VEL_W-1:0]  velocity,
  output logic [gpcs_pkg::BYTE_W-1:0]        current,
  output logic [gpcs_pkg::BYTE_W-1:0]        fault
);
  import gpcs_pkg::*;

  gpcs_cfg_t    cfg;
  gpcs_job_t    front_job;
  gpcs_job_t    head_job;
  gpcs_result_t res;
  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_not_empty;

  // Front: take the item, decode status, pick the final command, track state
  gpcs_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .activate_request (activate_request),
    .hold_request     (hold_request),
    .new_target       (new_target),
    .target_position  (target_position),
    .target_speed     (target_speed),
    .target_force     (target_force),
    .status_byte      (status_byte),
    .fault_byte       (fault_byte),
    .position_raw     (position_raw),
    .current_raw      (current_raw),
    .elapsed_us       (elapsed_us),
    .q_full           (q_full),
    .push             (push),
    .job              (front_job),
    .cfg              (cfg)
  );

  // Hold classified polls until the back is free
  gpcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .job_in    (front_job),
    .pop       (pop),
    .job_out   (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: divide, then emit the results of one poll in order
  gpcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  // Break the output register out to the result ports
  assign kind         = res.kind;
  assign last         = res.last;
  assign action_code  = res.action_code;
  assign cmd_position = res.cmd_position;
  assign cmd_speed    = res.cmd_speed;
  assign cmd_force    = res.cmd_force;
  assign activated    = res.activated;
  assign moving       = res.moving;
  assign position     = res.position;
  assign velocity     = $signed(res.velocity);
  assign current      = res.current;
  assign fault        = res.fault;

endmodule

// File: design/gpcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_front
// Accepts poll items, holds the configuration and the per-poll state,
// decodes status and picks the final command of each poll.
// ----------------------------------------------------------------------------
module gpcs_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [gpcs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gpcs_pkg::BYTE_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   activate_request,
  input  logic                                   hold_request,
  input  logic                                   new_target,
  input  logic [gpcs_pkg::FRAC_W-1:0]            target_position,
  input  logic [gpcs_pkg::FRAC_W-1:0]            target_speed,
  input  logic [gpcs_pkg::FRAC_W-1:0]            target_force,
  input  logic [gpcs_pkg::BYTE_W-1:0]            status_byte,
  input  logic [gpcs_pkg::BYTE_W-1:0]            fault_byte,
  input  logic [gpcs_pkg::BYTE_W-1:0]            position_raw,
  input  logic [gpcs_pkg::BYTE_W-1:0]            current_raw,
  input  logic [gpcs_pkg::ELAPSED_W-1:0]         elapsed_us,
  input  logic                                   q_full,
  output logic                                   push,
  output gpcs_pkg::gpcs_job_t                    job,
  output gpcs_pkg::gpcs_cfg_t                    cfg
);
  import gpcs_pkg::*;

  localparam int TR_W = FRAC_W + 10;
  localparam int CL_W = FRAC_W + 5;
  localparam logic [CL_W-1:0] CLOSE_RATIO = CL_W'(20);

  function automatic logic [FRAC_W-1:0] clamp_q(input logic [FRAC_W-1:0] v);
    clamp_q = (v > ONE_Q) ? ONE_Q : v;
  endfunction

  // round(255 * v), halves up
  function automatic logic [BYTE_W-1:0] frac_to_byte(input logic [FRAC_W-1:0] v);
    logic [FRAC_W-1:0]   c;
    logic [FRAC_W+7:0]   acc;
    c   = clamp_q(v);
    acc = ({c, 8'b0} - {8'b0, c}) + (FRAC_W + 8)'(ONE_Q >> 1);
    frac_to_byte = acc[FRAC_BITS +: BYTE_W];
  endfunction

  logic [BYTE_W-1:0] open_position;
  logic [BYTE_W-1:0] closed_position;
  logic [BYTE_W-1:0] previous_position_raw;
  logic              command_pending;
  logic              command_pending_next;

  logic                    activated;
  logic                    moving;
  logic                    pending_eff;
  logic                    near_closed;
  logic [FRAC_W-1:0]       c_tpos;
  logic signed [8:0]       span_s;
  logic signed [TR_W-1:0]  t_base;
  logic signed [TR_W-1:0]  t_prod;
  logic signed [TR_W-1:0]  t_half;
  logic signed [TR_W-1:0]  t_acc;
  logic [BYTE_W-1:0]       goto_raw;
  logic [BYTE_W-1:0]       speed_b;
  logic [BYTE_W-1:0]       force_raw_b;
  logic [BYTE_W-1:0]       force_b;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign cfg.open_position   = open_position;
  assign cfg.closed_position = closed_position;

  always_comb begin
    activated   = status_byte[0] && status_byte[5] && status_byte[4];
    moving      = status_byte[3] && !status_byte[7] && !status_byte[6];
    pending_eff = command_pending || new_target;

    // target fraction to raw byte: round(closed - t * span), floor at zero
    c_tpos   = clamp_q(target_position);
    span_s   = $signed({1'b0, closed_position}) - $signed({1'b0, open_position});
    t_base   = TR_W'($signed({1'b0, closed_position, {FRAC_BITS{1'b0}}}));
    t_prod   = TR_W'($signed({1'b0, c_tpos})) * TR_W'(span_s);
    t_half   = TR_W'(ONE_Q >> 1);
    t_acc    = t_base - t_prod + t_half;
    goto_raw = t_acc[TR_W-1] ? '0 : t_acc[FRAC_BITS +: BYTE_W];

    // target below 5 percent
    near_closed = (CL_W'(c_tpos) * CLOSE_RATIO) < CL_W'(ONE_Q);

    speed_b     = frac_to_byte(target_speed);
    force_raw_b = frac_to_byte(target_force);
    // keep a nonzero force request from collapsing to zero
    force_b     = (force_raw_b == '0 && target_force != '0) ? 8'd1 : force_raw_b;
  end

  always_comb begin
    job.act_req      = activate_request;
    job.activated    = activated;
    job.moving       = moving;
    job.has_final    = 1'b0;
    job.fin_action   = ACT_ENABLE_GO;
    job.fin_position = goto_raw;
    job.fin_speed    = speed_b;
    job.fin_force    = force_b;
    job.prev_raw     = previous_position_raw;
    job.raw          = position_raw;
    job.current      = current_raw;
    job.fault        = fault_byte;
    job.elapsed      = elapsed_us;
    command_pending_next = pending_eff;

    if (activated && hold_request) begin
      job.has_final        = 1'b1;
      job.fin_action       = ACT_ENABLE;
      job.fin_position     = position_raw;
      command_pending_next = 1'b0;
    end else if (activated && pending_eff) begin
      job.has_final        = 1'b1;
      command_pending_next = 1'b0;
    end else if (activated && near_closed && !moving) begin
      // re-grasp: close again
      job.has_final    = 1'b1;
      job.fin_position = closed_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_position         <= 8'd0;
      closed_position       <= 8'd255;
      previous_position_raw <= 8'd0;
      command_pending       <= 1'b1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_OPEN: begin
            open_position <= cfg_data;
            if (!push) begin
              previous_position_raw <= cfg_data;
            end
          end
          CFG_CLOSED: begin
            closed_position <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (push) begin
        previous_position_raw <= position_raw;
        command_pending       <= command_pending_next;
      end
    end
  end

endmodule

// File: design/gpcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_queue
// Short first-in first-out queue of classified polls between front and back.
// ----------------------------------------------------------------------------
module gpcs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gpcs_pkg::gpcs_job_t job_in,
  input  logic                pop,
  output gpcs_pkg::gpcs_job_t job_out,
  output logic                full,
  output logic                not_empty
);
  import gpcs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gpcs_job_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign job_out   = slots[rd_ptr];
  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue read while empty");

endmodule

// File: design/gpcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_div
// Restoring unsigned divider, one quotient bit per cycle, step count per run.
// ----------------------------------------------------------------------------
module gpcs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [gpcs_pkg::DIV_N-1:0]     dividend,
  input  logic [gpcs_pkg::DIV_D-1:0]     divisor,
  input  logic [gpcs_pkg::DIV_CNT_W-1:0] steps,
  output logic                           busy,
  output logic                           done,
  output logic [gpcs_pkg::DIV_N-1:0]     quotient
);
  import gpcs_pkg::*;

  logic [DIV_N-1:0]     quo;
  logic [DIV_D-1:0]     rem;
  logic [DIV_D-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D:0]       trial;
  logic [DIV_D+1:0]     diff;
  logic                 fit;

  assign quotient = quo;

  always_comb begin
    trial = {rem, quo[DIV_N-1]};
    diff  = {1'b0, trial} - {2'b0, dvs};
    fit   = !diff[DIV_D+1];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N-2:0], fit};
      rem <= fit ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/gpcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcs_back
// Carries out one poll: position and velocity through the shared divider,
// then the command writes and state report through the output register.
// ----------------------------------------------------------------------------
module gpcs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  gpcs_pkg::gpcs_cfg_t    cfg,
  input  logic                   q_not_empty,
  input  gpcs_pkg::gpcs_job_t    q_job,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gpcs_pkg::gpcs_result_t res
);
  import gpcs_pkg::*;

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W - 1){1'b0}}};

  gpcs_state_t state;
  gpcs_state_t state_next;
  gpcs_slot_t  slot;
  gpcs_job_t   job;

  logic [FRAC_W-1:0] pos_q;
  logic [VEL_W-1:0]  vel_q;
  logic [DIV_N-1:0]  vel_num;
  logic [DIV_D-1:0]  vel_den;
  logic              vel_neg;
  logic              vel_skip;

  logic                  div_start;
  logic                  div_sel_vel;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_N-1:0]      div_quo;
  logic [DIV_N-1:0]      div_dividend;
  logic [DIV_D-1:0]      div_divisor;
  logic [DIV_CNT_W-1:0]  div_steps;

  logic                  pos_load;
  logic                  vel_load;
  logic                  out_load;
  logic                  slot_last;
  gpcs_result_t          res_next;

  logic signed [8:0]     span_s;
  logic                  span_pos;
  logic [BYTE_W-1:0]     span_mag;
  logic signed [8:0]     num_s;
  logic [BYTE_W-1:0]     num_c;
  logic [POS_W-1:0]      pos_dividend;
  logic signed [8:0]     diff_s;
  logic [BYTE_W-1:0]     diff_mag;
  logic [BYTE_W+USEC_W-1:0] mag_us;
  logic [FRAC_W-1:0]     pos_value;
  logic [VEL_W-1:0]      vel_value;

  // Operand preparation
  always_comb begin
    span_s   = $signed({1'b0, cfg.closed_position}) - $signed({1'b0, cfg.open_position});
    span_pos = !span_s[8] && (span_s != '0);
    span_mag = span_s[8] ? 8'(-span_s) : span_s[7:0];

    num_s = $signed({1'b0, cfg.closed_position}) - $signed({1'b0, job.raw});
    if (num_s[8]) begin
      num_c = '0;
    end else if (num_s > span_s) begin
      num_c = span_s[7:0];
    end else begin
      num_c = num_s[7:0];
    end
    pos_dividend = {num_c, {FRAC_BITS{1'b0}}} + POS_W'(span_s[7:1]);

    diff_s   = $signed({1'b0, job.prev_raw}) - $signed({1'b0, job.raw});
    diff_mag = diff_s[8] ? 8'(-diff_s) : diff_s[7:0];
    mag_us   = (BYTE_W + USEC_W)'(diff_mag) * (BYTE_W + USEC_W)'(USEC_PER_SEC);

    div_dividend = div_sel_vel ? vel_num : {pos_dividend, {(DIV_N - POS_W){1'b0}}};
    div_divisor  = div_sel_vel ? vel_den : DIV_D'(span_mag);
    div_steps    = div_sel_vel ? DIV_CNT_W'(DIV_N) : DIV_CNT_W'(POS_W);

    pos_value = span_pos ? div_quo[FRAC_W-1:0] : ONE_Q;

    // truncate toward zero, saturate to 32 bits signed
    if (vel_skip) begin
      vel_value = '0;
    end else if (!vel_neg) begin
      vel_value = (div_quo > DIV_N'(VEL_MAX)) ? VEL_MAX : div_quo[VEL_W-1:0];
    end else begin
      vel_value = (div_quo > DIV_N'(VEL_MIN)) ? VEL_MIN : -div_quo[VEL_W-1:0];
    end
  end

  // Result for the current slot
  always_comb begin
    res_next  = '0;
    slot_last = 1'b0;
    case (slot)
      SLOT_RESET: begin
        res_next.action_code = ACT_RESET;
      end
      SLOT_ENABLE: begin
        res_next.action_code  = ACT_ENABLE;
        res_next.cmd_position = cfg.open_position;
        res_next.cmd_speed    = FULL_SPEED;
        res_next.cmd_force    = ACT_FORCE;
      end
      SLOT_REPORT: begin
        slot_last          = !job.has_final;
        res_next.kind      = KIND_REPORT;
        res_next.activated = job.activated;
        res_next.moving    = job.moving;
        res_next.position  = pos_q;
        res_next.velocity  = vel_q;
        res_next.current   = job.current;
        res_next.fault     = job.fault;
      end
      SLOT_FINAL: begin
        slot_last             = 1'b1;
        res_next.action_code  = job.fin_action;
        res_next.cmd_position = job.fin_position;
        res_next.cmd_speed    = job.fin_speed;
        res_next.cmd_force    = job.fin_force;
      end
      default: begin
      end
    endcase
    res_next.last = slot_last;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_not_empty) state_next = ST_PREP;
      ST_PREP: state_next = ST_POS;
      ST_POS:  if (div_done) state_next = ST_VEL;
      ST_VEL:  if (div_done) state_next = ST_EMIT;
      ST_EMIT: if (out_load && slot_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop         = 1'b0;
    div_start   = 1'b0;
    div_sel_vel = 1'b0;
    pos_load    = 1'b0;
    vel_load    = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: pop = q_not_empty;
      ST_PREP: div_start = 1'b1;
      ST_POS: begin
        div_sel_vel = 1'b1;
        div_start   = div_done;
        pos_load    = div_done;
      end
      ST_VEL:  vel_load = div_done;
      ST_EMIT: out_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  gpcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
    if (state == ST_PREP) begin
      vel_num  <= {mag_us, {FRAC_BITS{1'b0}}};
      vel_den  <= DIV_D'(span_mag) * DIV_D'(job.elapsed);
      vel_neg  <= diff_s[8] ^ span_s[8];
      vel_skip <= (span_s == '0) || (job.elapsed == '0);
    end
    if (pos_load) begin
      pos_q <= pos_value;
    end
    if (vel_load) begin
      vel_q <= vel_value;
    end
    if (out_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= SLOT_REPORT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        slot <= job.act_req ? SLOT_RESET : SLOT_REPORT;
      end else if (out_load) begin
        slot <= gpcs_slot_t'(slot + 1'b1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy)
    else $error("divider running with no poll in progress");

  a_last_ends_poll: assert property (@(posedge clk) disable iff (rst)
    (out_load && slot_last) |=> (state == ST_IDLE) && out_valid && res.last)
    else $error("final result of a poll did not close the poll");

endmodule
